FILE: sv/dcaq_pkg.sv
`default_nettype none

package dcaq_pkg;

  localparam int unsigned ID_FIELD_W = 6;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] MAX_MELEE_RST  = 7'd4;
  localparam logic [CNT_W-1:0] MAX_RANGED_RST = 7'd2;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_ENQ_MELEE  = 3'd1,
    REQ_ENQ_RANGED = 3'd2,
    REQ_REMOVE     = 3'd3,
    REQ_MARK_DEAD  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DUP        = 2'd1,
    ST_FULL       = 2'd2,
    ST_NOT_ACTIVE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_MELEE  = 2'd0,
    CFG_MAX_RANGED = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic dup;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: sv/dcaq_ram.sv
`default_nettype none

module dcaq_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/dcaq_queue.sv
`default_nettype none

module dcaq_queue #(
  parameter int unsigned ID_BITS     = 6,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dcaq_pkg::q_cmd_t   cmd,
  input  wire logic [ID_BITS-1:0] push_id,
  output dcaq_pkg::q_stat_t       stat,
  output logic      [ID_BITS-1:0] head_id
);

  import dcaq_pkg::*;

  localparam int unsigned AW      = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NUM_IDS = 1 << ID_BITS;

  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [NUM_IDS-1:0] waiting_r, waiting_nxt;
  logic               byp_r;
  logic [ID_BITS-1:0] byp_data_r;
  logic [ID_BITS-1:0] ram_rdata;
  logic               do_push, do_pop;

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FW'(QUEUE_DEPTH));
  assign stat.dup   = waiting_r[push_id];

  assign do_push = cmd.push && !stat.dup && !stat.full;
  assign do_pop  = cmd.pop && !stat.empty;

  assign head_id = byp_r ? byp_data_r : ram_rdata;

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    waiting_nxt = waiting_r;
    if (do_push) begin
      tail_nxt             = (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      fill_nxt             = fill_r + 1'b1;
      waiting_nxt[push_id] = 1'b1;
    end else if (do_pop) begin
      head_nxt             = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      fill_nxt             = fill_r - 1'b1;
      waiting_nxt[head_id] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
      waiting_r <= '0;
      byp_r     <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
      waiting_r <= waiting_nxt;
      // write into an empty queue hits the address being read
      byp_r     <= do_push && stat.empty;
    end
    byp_data_r <= push_id;
  end

  dcaq_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (tail_r),
    .wdata (push_id),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(QUEUE_DEPTH))
    else $error("queue fill exceeds depth");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_push && do_pop))
    else $error("push and pop in the same cycle");

  a_pop_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> !waiting_r[$past(head_id)])
    else $error("popped id still marked waiting");
`endif

endmodule

`default_nettype wire

FILE: sv/dual_class_admission_queue.sv
`default_nettype none

// Dual-class admission queue. An item is taken on every cycle that start is
// high (busy stays low), and its single result appears in the next cycle on the
// out_ ports for exactly that one cycle, marked by out_valid; the receiver
// cannot stall, so it must sample every strobe. The wait queues live in RAMs
// with a registered read that is always pointed at the next head. Limits are
// written through the cfg_ port, which is always ready; the user must write
// them only while no item is in flight, as the block does not enforce this.
module dual_class_admission_queue #(
  parameter int unsigned ID_BITS     = 6,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [2:0]                          in_req_type,
  input  wire logic [dcaq_pkg::ID_FIELD_W-1:0]     in_entity_id,
  input  wire logic                                in_is_melee,
  output logic                                     out_valid,
  output logic [1:0]                               out_status,
  output logic                                     out_melee_admitted,
  output logic [dcaq_pkg::ID_FIELD_W-1:0]          out_melee_admit_id,
  output logic                                     out_ranged_admitted,
  output logic [dcaq_pkg::ID_FIELD_W-1:0]          out_ranged_admit_id,
  output logic [dcaq_pkg::CNT_W-1:0]               out_melee_active_count,
  output logic [dcaq_pkg::CNT_W-1:0]               out_ranged_active_count,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dcaq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dcaq_pkg::CNT_W-1:0]          cfg_data
);

  import dcaq_pkg::*;

  localparam int unsigned NUM_IDS = 1 << ID_BITS;

  logic [CNT_W-1:0]   max_m_r, max_r_r;
  logic [CNT_W-1:0]   m_cnt_r, m_cnt_nxt;
  logic [CNT_W-1:0]   r_cnt_r, r_cnt_nxt;
  logic [NUM_IDS-1:0] active_r, active_nxt;
  logic [NUM_IDS-1:0] alive_r, alive_nxt;

  logic               out_valid_r;
  logic [1:0]         status_r;
  logic               m_adm_r, r_adm_r;
  logic [ID_FIELD_W-1:0] m_id_r, r_id_r;

  logic               acc;
  req_t               req;
  logic [ID_BITS-1:0] id;
  q_cmd_t             m_cmd, r_cmd;
  q_stat_t            m_stat, r_stat;
  logic [ID_BITS-1:0] m_head, r_head;
  logic               m_adm, r_adm;
  status_t            status;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;
  assign req       = req_t'(in_req_type);
  assign id        = ID_BITS'(in_entity_id);

  assign m_cmd.push = acc && (req == REQ_ENQ_MELEE);
  assign m_cmd.pop  = acc && (req == REQ_TICK) && (m_cnt_r < max_m_r);
  assign r_cmd.push = acc && (req == REQ_ENQ_RANGED);
  assign r_cmd.pop  = acc && (req == REQ_TICK) && (r_cnt_r < max_r_r);

  assign m_adm = m_cmd.pop && !m_stat.empty && alive_r[m_head];
  assign r_adm = r_cmd.pop && !r_stat.empty && alive_r[r_head];

  always_comb begin
    m_cnt_nxt  = m_cnt_r;
    r_cnt_nxt  = r_cnt_r;
    active_nxt = active_r;
    alive_nxt  = alive_r;
    status     = ST_OK;
    if (acc) begin
      unique case (req)
        REQ_TICK: begin
          if (m_adm) begin
            active_nxt[m_head] = 1'b1;
            m_cnt_nxt          = (m_cnt_r == CNT_MAX) ? m_cnt_r : m_cnt_r + 1'b1;
          end
          if (r_adm) begin
            active_nxt[r_head] = 1'b1;
            r_cnt_nxt          = (r_cnt_r == CNT_MAX) ? r_cnt_r : r_cnt_r + 1'b1;
          end
        end
        REQ_ENQ_MELEE: begin
          alive_nxt[id] = 1'b1;
          status = m_stat.dup ? ST_DUP : (m_stat.full ? ST_FULL : ST_OK);
        end
        REQ_ENQ_RANGED: begin
          alive_nxt[id] = 1'b1;
          status = r_stat.dup ? ST_DUP : (r_stat.full ? ST_FULL : ST_OK);
        end
        REQ_REMOVE: begin
          if (active_r[id]) begin
            active_nxt[id] = 1'b0;
            if (in_is_melee) begin
              m_cnt_nxt = (m_cnt_r == '0) ? m_cnt_r : m_cnt_r - 1'b1;
            end else begin
              r_cnt_nxt = (r_cnt_r == '0) ? r_cnt_r : r_cnt_r - 1'b1;
            end
          end else begin
            status = ST_NOT_ACTIVE;
          end
        end
        REQ_MARK_DEAD: begin
          alive_nxt[id] = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_m_r     <= MAX_MELEE_RST;
      max_r_r     <= MAX_RANGED_RST;
      m_cnt_r     <= '0;
      r_cnt_r     <= '0;
      active_r    <= '0;
      alive_r     <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_MELEE) begin
          max_m_r <= cfg_data;
        end else if (cfg_index == CFG_MAX_RANGED) begin
          max_r_r <= cfg_data;
        end
      end
      m_cnt_r     <= m_cnt_nxt;
      r_cnt_r     <= r_cnt_nxt;
      active_r    <= active_nxt;
      alive_r     <= alive_nxt;
      out_valid_r <= acc;
    end
    status_r <= status;
    m_adm_r  <= m_adm;
    r_adm_r  <= r_adm;
    m_id_r   <= m_adm ? ID_FIELD_W'(m_head) : '0;
    r_id_r   <= r_adm ? ID_FIELD_W'(r_head) : '0;
  end

  assign out_valid               = out_valid_r;
  assign out_status              = status_r;
  assign out_melee_admitted      = m_adm_r;
  assign out_melee_admit_id      = m_id_r;
  assign out_ranged_admitted     = r_adm_r;
  assign out_ranged_admit_id     = r_id_r;
  assign out_melee_active_count  = m_cnt_r;
  assign out_ranged_active_count = r_cnt_r;

  dcaq_queue #(
    .ID_BITS     (ID_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_melee_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (m_cmd),
    .push_id (id),
    .stat    (m_stat),
    .head_id (m_head)
  );

  dcaq_queue #(
    .ID_BITS     (ID_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ranged_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (r_cmd),
    .push_id (id),
    .stat    (r_stat),
    .head_id (r_head)
  );

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted transaction produced no result");

  a_admit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_melee_admitted) |-> (out_melee_active_count != '0))
    else $error("class0 admit with zero count");

  a_admit_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (!out_melee_admitted && !out_ranged_admitted))
    else $error("admission reported with non-ok status");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dcaq_pkg::*;

  localparam int FIFO_DEPTH = 16;
  localparam int MELEE      = 0;
  localparam int RANGED     = 1;

  typedef struct packed {
    logic [2:0] req;
    logic [5:0] id;
    logic       melee;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       m_adm;
    logic [5:0] m_id;
    logic       r_adm;
    logic [5:0] r_id;
    logic [6:0] m_cnt;
    logic [6:0] r_cnt;
  } admit_res_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             start       = 1'b0;
  logic [2:0]       in_req_type = '0;
  logic [5:0]       in_entity_id = '0;
  logic             in_is_melee = 1'b0;
  logic             cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data    = '0;
  logic             cfg_ready;
  logic             busy;
  logic             out_valid;
  logic [1:0]       out_status;
  logic             out_melee_admitted;
  logic [5:0]       out_melee_admit_id;
  logic             out_ranged_admitted;
  logic [5:0]       out_ranged_admit_id;
  logic [CNT_W-1:0] out_melee_active_count;
  logic [CNT_W-1:0] out_ranged_active_count;

  dual_class_admission_queue #(
    .ID_BITS     (6),
    .QUEUE_DEPTH (FIFO_DEPTH)
  ) u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_req_type             (in_req_type),
    .in_entity_id            (in_entity_id),
    .in_is_melee             (in_is_melee),
    .out_valid               (out_valid),
    .out_status              (out_status),
    .out_melee_admitted      (out_melee_admitted),
    .out_melee_admit_id      (out_melee_admit_id),
    .out_ranged_admitted     (out_ranged_admitted),
    .out_ranged_admit_id     (out_ranged_admit_id),
    .out_melee_active_count  (out_melee_active_count),
    .out_ranged_active_count (out_ranged_active_count),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  always #5 clk = ~clk;

  // Admission state mirror
  logic [5:0]  wait_fifo [2][$];
  logic [63:0] waiting_map [2];
  logic [63:0] active_map;
  logic [63:0] alive_map;
  logic [6:0]  active_cnt [2];
  logic [6:0]  cnt_limit [2];

  req_item_t   pending_reqs [$];
  admit_res_t  expected_admits [$];
  req_item_t   cur_req;
  bit          steady_run = 1'b0;
  int          errors = 0;

  function automatic logic [1:0] enqueue_waiter(int c, logic [5:0] id);
    alive_map[id] = 1'b1;
    if (waiting_map[c][id]) return ST_DUP;
    if (wait_fifo[c].size() >= FIFO_DEPTH) return ST_FULL;
    wait_fifo[c].push_back(id);
    waiting_map[c][id] = 1'b1;
    return ST_OK;
  endfunction

  function automatic logic serve_class(int c, output logic [5:0] who);
    logic [5:0] id;
    who = '0;
    if (active_cnt[c] >= cnt_limit[c] || wait_fifo[c].size() == 0) return 1'b0;
    id = wait_fifo[c].pop_front();
    waiting_map[c][id] = 1'b0;
    if (!alive_map[id]) return 1'b0;
    if (active_cnt[c] != CNT_MAX) active_cnt[c] = active_cnt[c] + 7'd1;
    active_map[id] = 1'b1;
    who = id;
    return 1'b1;
  endfunction

  function automatic admit_res_t admission_step(req_item_t r);
    admit_res_t res;
    int c;
    res = '0;
    case (r.req)
      REQ_TICK: begin
        res.m_adm = serve_class(MELEE, res.m_id);
        res.r_adm = serve_class(RANGED, res.r_id);
      end
      REQ_ENQ_MELEE:  res.status = enqueue_waiter(MELEE, r.id);
      REQ_ENQ_RANGED: res.status = enqueue_waiter(RANGED, r.id);
      REQ_REMOVE: begin
        if (active_map[r.id]) begin
          active_map[r.id] = 1'b0;
          c = r.melee ? MELEE : RANGED;
          if (active_cnt[c] != 0) active_cnt[c] = active_cnt[c] - 7'd1;
        end else begin
          res.status = ST_NOT_ACTIVE;
        end
      end
      REQ_MARK_DEAD: alive_map[r.id] = 1'b0;
      default: ;
    endcase
    res.m_cnt = active_cnt[MELEE];
    res.r_cnt = active_cnt[RANGED];
    return res;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Driver
  always @(posedge clk) begin : drive
    logic launch;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_admits.push_back(admission_step(cur_req));
      if (!(start && busy)) begin
        launch = pending_reqs.size() != 0 && (steady_run || $urandom_range(99) >= 7);
        if (launch) begin
          cur_req = pending_reqs.pop_front();
          in_req_type  <= cur_req.req;
          in_entity_id <= cur_req.id;
          in_is_melee  <= cur_req.melee;
        end
        start <= launch;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin : watch
    admit_res_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_admits.size() == 0) begin
        $display("%0t unexpected transaction: expected none actual status %0d",
                 $time, out_status);
        errors++;
      end else begin
        exp_r = expected_admits.pop_front();
        check_field("status", exp_r.status, out_status);
        check_field("melee_admitted", exp_r.m_adm, out_melee_admitted);
        check_field("melee_admit_id", exp_r.m_id, out_melee_admit_id);
        check_field("ranged_admitted", exp_r.r_adm, out_ranged_admitted);
        check_field("ranged_admit_id", exp_r.r_id, out_ranged_admit_id);
        check_field("melee_active_count", exp_r.m_cnt, out_melee_active_count);
        check_field("ranged_active_count", exp_r.r_cnt, out_ranged_active_count);
      end
    end
  end

  function automatic req_item_t mk_req(logic [2:0] q, logic [5:0] id, logic m);
    req_item_t r;
    r.req   = q;
    r.id    = id;
    r.melee = m;
    return r;
  endfunction

  function automatic req_item_t rand_req();
    req_item_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)      r.req = REQ_TICK;
    else if (pick < 52) r.req = REQ_ENQ_MELEE;
    else if (pick < 74) r.req = REQ_ENQ_RANGED;
    else if (pick < 88) r.req = REQ_REMOVE;
    else if (pick < 96) r.req = REQ_MARK_DEAD;
    else                r.req = 3'(REQ_MARK_DEAD) + 3'($urandom_range(1, 3));
    r.id    = ($urandom_range(99) < 70) ? 6'($urandom_range(11)) : 6'($urandom_range(63));
    r.melee = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic settle();
    while (pending_reqs.size() != 0 || start || expected_admits.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_batch(int n);
    repeat (n) pending_reqs.push_back(rand_req());
    settle();
  endtask

  task automatic write_limit(cfg_idx_t idx, logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cnt_limit[(idx == CFG_MAX_MELEE) ? MELEE : RANGED] = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(logic [6:0] melee_lim, logic [6:0] ranged_lim);
    write_limit(CFG_MAX_MELEE, melee_lim);
    write_limit(CFG_MAX_RANGED, ranged_lim);
  endtask

  initial begin
    waiting_map[MELEE]  = '0;
    waiting_map[RANGED] = '0;
    active_map          = '0;
    alive_map           = '1;
    active_cnt[MELEE]   = '0;
    active_cnt[RANGED]  = '0;
    cnt_limit[MELEE]    = MAX_MELEE_RST;
    cnt_limit[RANGED]   = MAX_RANGED_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: dup, dead head dropped, removes, unused codes, re-admission
    pending_reqs.push_back(mk_req(REQ_TICK, 6'd0, 1'b0));
    pending_reqs.push_back(mk_req(REQ_ENQ_MELEE, 6'd0, 1'b0));
    pending_reqs.push_back(mk_req(REQ_ENQ_MELEE, 6'd0, 1'b1));
    pending_reqs.push_back(mk_req(REQ_ENQ_RANGED, 6'd5, 1'b0));
    pending_reqs.push_back(mk_req(REQ_MARK_DEAD, 6'd5, 1'b0));
    pending_reqs.push_back(mk_req(REQ_TICK, 6'd63, 1'b1));
    pending_reqs.push_back(mk_req(REQ_ENQ_RANGED, 6'd63, 1'b1));
    pending_reqs.push_back(mk_req(REQ_MARK_DEAD, 6'd63, 1'b0));
    pending_reqs.push_back(mk_req(REQ_ENQ_RANGED, 6'd63, 1'b0));
    pending_reqs.push_back(mk_req(REQ_TICK, 6'd0, 1'b0));
    pending_reqs.push_back(mk_req(REQ_REMOVE, 6'd0, 1'b1));
    pending_reqs.push_back(mk_req(REQ_REMOVE, 6'd0, 1'b1));
    pending_reqs.push_back(mk_req(REQ_REMOVE, 6'd63, 1'b1));
    pending_reqs.push_back(mk_req(3'(REQ_MARK_DEAD) + 3'd1, 6'd42, 1'b1));
    pending_reqs.push_back(mk_req(3'(REQ_MARK_DEAD) + 3'd2, 6'd21, 1'b0));
    pending_reqs.push_back(mk_req(3'(REQ_MARK_DEAD) + 3'd3, 6'd63, 1'b1));
    pending_reqs.push_back(mk_req(REQ_ENQ_MELEE, 6'd9, 1'b0));
    pending_reqs.push_back(mk_req(REQ_TICK, 6'd0, 1'b0));
    pending_reqs.push_back(mk_req(REQ_ENQ_MELEE, 6'd9, 1'b0));
    pending_reqs.push_back(mk_req(REQ_TICK, 6'd0, 1'b0));
    pending_reqs.push_back(mk_req(REQ_REMOVE, 6'd9, 1'b0));
    pending_reqs.push_back(mk_req(REQ_MARK_DEAD, 6'd62, 1'b1));
    run_batch(250);

    set_limits(7'd0, 7'd0);
    run_batch(200);
    set_limits(7'd64, 7'd1);
    run_batch(300);
    set_limits(7'd1, 7'd64);
    run_batch(300);
    steady_run = 1'b1;
    set_limits(7'd64, 7'd64);
    run_batch(350);
    steady_run = 1'b0;
    repeat (3) begin
      set_limits(7'($urandom_range(64)), 7'($urandom_range(64)));
      run_batch(150);
    end

    repeat (5) @(posedge clk);
    if (errors == 0 && expected_admits.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
